@@ rtl/rdh_pkg.sv @@
// ----------------------------------------------------------------------------
// rdh_pkg
// Shared types, constants and the bin mapping for the reuse distance
// histogram.
// ----------------------------------------------------------------------------
package rdh_pkg;

   // Histogram geometry
   localparam int NUM_BINS      = 1024;
   localparam int LINEAR_SHIFT  = 10;
   localparam int CAPTURE_DEPTH = 1024;
   localparam int COUNT_WIDTH   = 48;
   localparam int CAPTURE_LISTS = 5;

   localparam int BIN_AW  = $clog2(NUM_BINS);
   localparam int CAP_AW  = $clog2(CAPTURE_LISTS * CAPTURE_DEPTH);
   localparam int HI_W    = 32 - LINEAR_SHIFT + 1;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   // Request codes
   localparam logic [1:0] REQ_RECORD   = 2'd0;
   localparam logic [1:0] REQ_RD_COUNT = 2'd1;
   localparam logic [1:0] REQ_RD_CAP   = 2'd2;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] distance;
      logic [63:0] address;
      logic [9:0]  bin_select;
      logic [9:0]  entry_index;
   } req_word_type;

   typedef struct packed {
      logic [9:0]  bin;
      logic [47:0] count;
      logic        captured;
      logic [63:0] read_address;
      logic        read_valid;
   } rsp_word_type;

   // Controller -> datapath
   typedef struct packed {
      logic clear_wr;
      logic load;
      logic mem_rd;
      logic update;
   } ctrl_cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic clear_last;
   } ctrl_status_type;

   // Log-linear bin of a distance: bit length below 2^LINEAR_SHIFT,
   // linear above, clamped at the last bin.
   function automatic logic [BIN_AW-1:0] bin_of(input logic [31:0] d);
      logic [BIN_AW-1:0] len;
      logic [HI_W-1:0]   hi_sum;
      len = '0;
      for (int i = 0; i < LINEAR_SHIFT; i++) begin
         if (d[i]) begin
            len = BIN_AW'(i + 1);
         end
      end
      hi_sum = {1'b0, d[31:LINEAR_SHIFT]} + HI_W'(LINEAR_SHIFT);
      if (d[31:LINEAR_SHIFT] == '0) begin
         return len;
      end else if (hi_sum > HI_W'(NUM_BINS - 1)) begin
         return BIN_AW'(NUM_BINS - 1);
      end else begin
         return hi_sum[BIN_AW-1:0];
      end
   endfunction

endpackage

@@ rtl/rdh_ctrl.sv @@
// ----------------------------------------------------------------------------
// rdh_ctrl
// Sequencer: clearing sweep after reset, then accept, read, update, respond.
// ----------------------------------------------------------------------------
module rdh_ctrl
   import rdh_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output ctrl_cmd_type    cmd,
   input  ctrl_status_type status
);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_READ   = 3'd2;
   localparam logic [2:0] ST_UPDATE = 3'd3;
   localparam logic [2:0] ST_RESP   = 3'd4;

   logic [2:0] state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

   always_comb begin
      cmd.clear_wr = (state_ff == ST_CLEAR);
      cmd.load     = (state_ff == ST_IDLE) && req_valid;
      cmd.mem_rd   = (state_ff == ST_READ);
      cmd.update   = (state_ff == ST_UPDATE);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_READ;
         end
         ST_READ:   state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_RESP;
         ST_RESP: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default:   state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_load_then_read: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> cmd.mem_rd)
      else $error("accepted word not followed by memory read");

   a_update_then_resp: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> (rsp_valid && req_stall))
      else $error("update not followed by response");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (req_stall && !cmd.clear_wr))
      else $error("input open while response pending");
`endif

endmodule

@@ rtl/rdh_datapath.sv @@
// ----------------------------------------------------------------------------
// rdh_datapath
// Count memory, capture memory, bin mapping and response register.
// ----------------------------------------------------------------------------
module rdh_datapath
   import rdh_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  req_word_type    req_word,
   input  ctrl_cmd_type    cmd,
   output ctrl_status_type status,
   output rsp_word_type    rsp_word
);

   logic [COUNT_WIDTH-1:0] cnt_mem [NUM_BINS];
   logic [63:0]            cap_mem [CAPTURE_LISTS * CAPTURE_DEPTH];

   req_word_type           req_ff;
   logic [BIN_AW-1:0]      bin_ff;
   logic [BIN_AW-1:0]      clr_ff;
   logic [COUNT_WIDTH-1:0] cnt_rd_ff;
   logic [63:0]            cap_rd_ff;
   rsp_word_type           rsp_ff, rsp_in;

   logic [COUNT_WIDTH-1:0] cnt_inc;
   logic                   cap_hit;
   logic [CAP_AW-1:0]      cap_wa;
   logic [CAP_AW-1:0]      cap_ra;
   logic [2:0]             rd_list;
   logic                   sel_in_range;
   logic                   sel_is_list;
   logic                   rd_hit;
   logic                   is_record;

   assign status.clear_last = (clr_ff == BIN_AW'(NUM_BINS - 1));
   assign rsp_word          = rsp_ff;

   // Clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_wr) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   // Capture the word and map it to a bin
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_word;
         if (req_word.req_type == REQ_RECORD) begin
            bin_ff <= bin_of(req_word.distance);
         end else begin
            bin_ff <= req_word.bin_select[BIN_AW-1:0];
         end
      end
   end

   assign is_record    = (req_ff.req_type == REQ_RECORD);
   assign sel_in_range = (32'(req_ff.bin_select) < 32'(NUM_BINS));
   assign sel_is_list  = (32'(req_ff.bin_select) < 32'(CAPTURE_LISTS));
   assign rd_list      = sel_is_list ? req_ff.bin_select[2:0] : 3'd0;
   assign cap_ra       = CAP_AW'(rd_list) * CAP_AW'(CAPTURE_DEPTH)
                       + CAP_AW'(req_ff.entry_index);

   // Memory read stage
   always_ff @(posedge clock) begin
      if (cmd.mem_rd) begin
         cnt_rd_ff <= cnt_mem[bin_ff];
         cap_rd_ff <= cap_mem[cap_ra];
      end
   end

   // Record update
   assign cnt_inc = (cnt_rd_ff == COUNT_MAX) ? cnt_rd_ff : cnt_rd_ff + 1'b1;
   assign cap_hit = is_record && (32'(bin_ff) < 32'(CAPTURE_LISTS))
                 && (cnt_rd_ff < COUNT_WIDTH'(CAPTURE_DEPTH));
   assign cap_wa  = CAP_AW'(bin_ff) * CAP_AW'(CAPTURE_DEPTH) + CAP_AW'(cnt_rd_ff);

   always_ff @(posedge clock) begin
      if (cmd.clear_wr) begin
         cnt_mem[clr_ff] <= '0;
      end else if (cmd.update && is_record) begin
         cnt_mem[bin_ff] <= cnt_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update && cap_hit) begin
         cap_mem[cap_wa] <= req_ff.address;
      end
   end

   // Capture read hit: inside the list's filled length
   assign rd_hit = sel_is_list && sel_in_range
                && (COUNT_WIDTH'(req_ff.entry_index) < cnt_rd_ff)
                && (32'(req_ff.entry_index) < 32'(CAPTURE_DEPTH));

   always_comb begin
      rsp_in = '0;
      unique case (req_ff.req_type)
         REQ_RECORD: begin
            rsp_in.bin      = 10'(bin_ff);
            rsp_in.count    = 48'(cnt_inc);
            rsp_in.captured = cap_hit;
         end
         REQ_RD_COUNT: begin
            rsp_in.bin   = req_ff.bin_select;
            rsp_in.count = sel_in_range ? 48'(cnt_rd_ff) : '0;
         end
         REQ_RD_CAP: begin
            rsp_in.bin          = req_ff.bin_select;
            rsp_in.count        = sel_in_range ? 48'(cnt_rd_ff) : '0;
            rsp_in.read_address = rd_hit ? cap_rd_ff : '0;
            rsp_in.read_valid   = rd_hit;
         end
         default: rsp_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

@@ rtl/reuse_distance_histogram_core.sv @@
// ----------------------------------------------------------------------------
// reuse_distance_histogram_core
// Log-linear histogram of reuse distances with per-bin address capture for
// the lowest five bins; bin counts and captured addresses read back.
// ----------------------------------------------------------------------------
//
//   channel  | handshake            | word
//   ---------+----------------------+------------------------------------
//   request  | req_valid/req_stall  | req_word  (record / read count / read cap)
//   response | rsp_valid/rsp_stall  | rsp_word  (one per request)
//
// Each word passes accept, memory read, update and write back, response,
// and any output stall; the controller walks one word at a time through the
// registered count memory read, so the next word waits for the response.
// After reset a clearing sweep zeroes all NUM_BINS (1024) count memory
// entries; req_stall stays high throughout.
// The capture memory is not cleared: entries are read only below the filled
// length. A stalled response holds, and no new word is taken until it goes.
//
module reuse_distance_histogram_core
   import rdh_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // request
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   // response
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   ctrl_cmd_type    cmd;     // sequencer commands
   ctrl_status_type status;  // sweep progress

   rdh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   rdh_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_word),
      .cmd      (cmd),
      .status   (status),
      .rsp_word (rsp_word)
   );

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the reuse distance histogram core. Record, count
// read and capture read words are driven in random bursts while the response
// side stalls on a pattern of its own. A scoreboard class keeps a shadow copy
// of the bin counts and capture lists and checks every response word in order.
// ----------------------------------------------------------------------------
module tb_top
   import rdh_pkg::*;
;

   localparam logic [1:0] REQ_UNUSED  = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 300000;
   localparam int          DRAIN_WAIT  = 16;
   localparam int          REPORT_MAX  = 10;

   // -------------------------------------------------------------------------
   // Shadow histogram and response checker
   // -------------------------------------------------------------------------
   class hist_scoreboard;
      logic [COUNT_WIDTH-1:0] bin_count [NUM_BINS];
      logic [63:0]            capture_list [CAPTURE_LISTS][CAPTURE_DEPTH];
      rsp_word_type           expected_q [$];
      int unsigned mismatches, checked;
      int unsigned n_records, n_captured, n_refused, n_count_reads;
      int unsigned n_cap_reads, n_cap_hits;

      function new();
         foreach (bin_count[i]) bin_count[i] = '0;
         foreach (capture_list[l, e]) capture_list[l][e] = '0;
      endfunction

      // Log-linear bin: bit length below the linear region, then one bin per
      // 2^LINEAR_SHIFT step, clamped at the top bin.
      function logic [9:0] bin_of_distance(logic [31:0] d);
         logic [31:0] upper;
         logic [32:0] linear;
         logic [9:0]  width;
         upper = d >> LINEAR_SHIFT;
         width = '0;
         if (upper == 0) begin
            for (int i = 0; i < 32; i++) begin
               if (d[i]) width = 10'(i + 1);
            end
            return width;
         end
         linear = {1'b0, upper} + 33'(LINEAR_SHIFT);
         if (linear > 33'(NUM_BINS - 1)) return 10'(NUM_BINS - 1);
         return linear[9:0];
      endfunction

      function void note_request(req_word_type w);
         rsp_word_type           e;
         logic [9:0]             b;
         logic [COUNT_WIDTH-1:0] c;
         logic [COUNT_WIDTH-1:0] filled;
         e = '0;
         case (w.req_type)
            REQ_RECORD: begin
               b = bin_of_distance(w.distance);
               c = bin_count[b];
               if (b < CAPTURE_LISTS && c < CAPTURE_DEPTH) begin
                  capture_list[b][c[9:0]] = w.address;
                  e.captured = 1'b1;
                  n_captured++;
               end else if (b < CAPTURE_LISTS) begin
                  n_refused++;
               end
               if (c != COUNT_MAX) c = c + 1'b1;
               bin_count[b] = c;
               e.bin   = b;
               e.count = c;
               n_records++;
            end
            REQ_RD_COUNT, REQ_RD_CAP: begin
               e.bin   = w.bin_select;
               e.count = bin_count[w.bin_select];
               if (w.req_type == REQ_RD_COUNT) begin
                  n_count_reads++;
               end else begin
                  n_cap_reads++;
                  if (w.bin_select < CAPTURE_LISTS) begin
                     filled = (e.count > CAPTURE_DEPTH) ? COUNT_WIDTH'(CAPTURE_DEPTH)
                                                        : e.count;
                     if (w.entry_index < filled) begin
                        e.read_address = capture_list[w.bin_select][w.entry_index];
                        e.read_valid   = 1'b1;
                        n_cap_hits++;
                     end
                  end
               end
            end
            default: ;  // unused code: no state change, all-zero word
         endcase
         expected_q.push_back(e);
      endfunction

      function void check_response(rsp_word_type r);
         rsp_word_type e;
         checked++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("%0t: response word with nothing outstanding: bin=%0d count=%0d",
                        $realtime, r.bin, r.count);
            return;
         end
         e = expected_q.pop_front();
         if (r.bin !== e.bin || r.count !== e.count || r.captured !== e.captured ||
             r.read_address !== e.read_address || r.read_valid !== e.read_valid) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
               $display("%0t: mismatch exp bin=%0d count=%0d cap=%0b addr=%h valid=%0b",
                        $realtime, e.bin, e.count, e.captured, e.read_address,
                        e.read_valid);
               $display("%0t:          got bin=%0d count=%0d cap=%0b addr=%h valid=%0b",
                        $realtime, r.bin, r.count, r.captured, r.read_address,
                        r.read_valid);
            end
         end
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and DUT
   // -------------------------------------------------------------------------
   logic         clock;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   hist_scoreboard sb = new();

   int unsigned cycle_count = 0;
   int          burst_left  = 0;
   int          fill_list;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   reuse_distance_histogram_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // -------------------------------------------------------------------------
   // Response side stall: a mode is held for a random stretch, so that free
   // running, light, heavy and run-like stalls all land on every phase.
   // -------------------------------------------------------------------------
   typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_mode_type;

   stall_mode_type stall_mode = STALL_NONE;
   logic [7:0]     stall_left = '0;

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_left <= 8'($urandom_range(20, 120));
      end else begin
         stall_left <= stall_left - 1'b1;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= stall_left[2];  // runs taken from bit 2 of the mode counter
      endcase
   end

   // Monitor: responses are checked before the same edge's request is noted,
   // so an early response can never match against its own request.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_word);
         if (req_valid && !req_stall) sb.note_request(req_word);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding",
                  cycle_count, sb.pending());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Word builders
   // -------------------------------------------------------------------------
   function automatic logic [63:0] random_address();
      return {$urandom(), $urandom()};
   endfunction

   function automatic req_word_type record_word(input logic [31:0] d,
                                                input logic [63:0] a);
      req_word_type w;
      w.req_type    = REQ_RECORD;
      w.distance    = d;
      w.address     = a;
      w.bin_select  = 10'($urandom);
      w.entry_index = 10'($urandom);
      return w;
   endfunction

   function automatic req_word_type read_word(input logic [1:0] kind,
                                              input logic [9:0] sel,
                                              input logic [9:0] idx);
      req_word_type w;
      w.req_type    = kind;
      w.distance    = $urandom;
      w.address     = random_address();
      w.bin_select  = sel;
      w.entry_index = idx;
      return w;
   endfunction

   // Distance that lands in one of the captured bins 0 to 4
   function automatic logic [31:0] low_bin_distance(input int k);
      if (k == 0) return '0;
      return $urandom_range((1 << (k - 1)), (1 << k) - 1);
   endfunction

   function automatic logic [31:0] random_distance();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return $urandom_range(1, 31);
         2:       return $urandom_range(1, 1023);
         3:       return $urandom_range(1024, (1013 << 10) + 1023);
         4:       return $urandom;
         default: return low_bin_distance($urandom_range(0, 4));
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Request driver: bursts of random length with random gaps between them
   // -------------------------------------------------------------------------
   task automatic issue(input req_word_type w);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
   endtask

   // Hold off until every outstanding response has come back, first waiting
   // until the monitor has noted the last accepted word.
   task automatic drain();
      req_valid  <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic random_mix(input int n);
      req_word_type w;
      logic [9:0]   sel;
      logic [9:0]   idx;
      int           pick;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            w = record_word(random_distance(), random_address());
         end else if (pick < 55) begin
            w = record_word(low_bin_distance($urandom_range(0, 4)), random_address());
         end else if (pick < 70) begin
            case ($urandom_range(0, 3))
               0, 1:    sel = 10'($urandom_range(0, 15));
               2:       sel = 10'($urandom_range(1000, 1023));
               default: sel = 10'($urandom);
            endcase
            w = read_word(REQ_RD_COUNT, sel, 10'($urandom));
         end else if (pick < 95) begin
            sel = ($urandom_range(0, 3) != 0) ? 10'($urandom_range(0, 4))
                                              : 10'($urandom);
            idx = ($urandom_range(0, 1) == 0) ? 10'($urandom_range(0, 31))
                                              : 10'($urandom);
            w = read_word(REQ_RD_CAP, sel, idx);
         end else begin
            w = read_word(REQ_UNUSED, 10'($urandom), 10'($urandom));
         end
         issue(w);
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      req_word_type w;
      int           limit;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: every bin region edge, list reads in and out of range,
      // the unused code with all bits set and all clear.
      issue(record_word(32'd0, '1));
      issue(record_word(32'd1, '0));
      issue(record_word(32'd3, 64'h0123_4567_89AB_CDEF));
      issue(record_word(32'd4, 64'h8000_0000_0000_0001));
      issue(record_word(32'd8, 64'hFEDC_BA98_7654_3210));
      issue(record_word(32'd16, random_address()));          // bin 5, no list
      issue(record_word(32'd1023, random_address()));        // top of log region
      issue(record_word(32'd1024, random_address()));        // first linear bin
      issue(record_word(32'h000F_D3FF, random_address()));   // bin 1022
      issue(record_word(32'h000F_D400, random_address()));   // exactly the last bin
      issue(record_word(32'hFFFF_FFFF, random_address()));   // clamped
      issue(record_word(32'h8000_0000, random_address()));   // clamped
      issue(read_word(REQ_RD_COUNT, 10'd0, '0));
      issue(read_word(REQ_RD_COUNT, 10'd1023, '1));
      issue(read_word(REQ_RD_COUNT, 10'd1022, '0));
      issue(read_word(REQ_RD_COUNT, 10'd11, '0));
      issue(read_word(REQ_RD_CAP, 10'd0, 10'd0));
      issue(read_word(REQ_RD_CAP, 10'd1, 10'd0));
      issue(read_word(REQ_RD_CAP, 10'd0, 10'd1));            // past filled length
      issue(read_word(REQ_RD_CAP, 10'd4, 10'd0));
      issue(read_word(REQ_RD_CAP, 10'd5, 10'd0));            // no list there
      issue(read_word(REQ_RD_CAP, 10'd1023, 10'd1023));
      w = '1;
      issue(w);                                              // unused code, all ones
      w = '0;
      w.req_type = REQ_UNUSED;
      issue(w);
      drain();

      // Fill one list past its depth, reading it back as it grows, so the
      // full-list refusal and the deepest entries get exercised.
      fill_list = $urandom_range(0, 4);
      for (int n = 0; n < 1040; n++) begin
         issue(record_word(low_bin_distance(fill_list), random_address()));
         if ($urandom_range(0, 7) == 0) begin
            limit = (n < 1023) ? n : 1023;
            issue(read_word(REQ_RD_CAP, 10'(fill_list), 10'($urandom_range(0, limit))));
         end
      end
      issue(read_word(REQ_RD_CAP, 10'(fill_list), 10'd1023));
      issue(read_word(REQ_RD_CAP, 10'(fill_list), 10'd1022));
      issue(read_word(REQ_RD_COUNT, 10'(fill_list), 10'd0));
      drain();

      random_mix(175);
      drain();
      random_mix(175);
      drain();

      $display("covered %0d records (%0d captured, %0d refused by a full list), %0d count reads",
               sb.n_records, sb.n_captured, sb.n_refused, sb.n_count_reads);
      $display("%0d capture reads (%0d hits), list %0d filled past depth, %0d words checked",
               sb.n_cap_reads, sb.n_cap_hits, fill_list, sb.checked);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches, %0d words outstanding", sb.mismatches, sb.pending());
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
